// ----- sv/positional_list_insert_erase_unit_defines.svh -----
// Assertion macros shared by the list unit.
// Each expects signals named clk and rst_n in the scope of use.
`ifndef POSITIONAL_LIST_INSERT_ERASE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_ERASE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PLIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define PLIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/plie_pkg.sv -----
package plie_pkg;

    // Store geometry
    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int LEN_W         = 7;
    localparam int POS_W         = 7;
    localparam int VALUE_W       = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        command_t             command;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   item_value;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   read_value;
        logic [LEN_W-1:0]     list_length;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic init_ptr;
        logic shift_step;
        logic put_word;
        logic read_issue;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic     is_ok;
        command_t command;
        logic     has_moves;
        logic     last_src;
    } dp_stat_t;

endpackage

// ----- sv/positional_list_insert_erase_unit.sv -----
// Ordered list of up to 64 words, packed from index 0, in a single-port-write
// memory. A command word (request) is taken at a clock edge where start is
// high and busy is low; busy then stays high until the command is finished.
// Commands: insert at a position up to the length, erase or read at a position
// below the length, clear. Each command gives one result word on result,
// marked by done for exactly one cycle; the receiver cannot hold it off.
// The move loop shifts one entry per cycle through the memory's read and write
// ports. busy drops during the cycle that shows the result, so the next
// command may be taken then.
// Reset empties the list; stored words are not cleared and are never visible
// past the length.
module positional_list_insert_erase_unit
    import plie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    plie_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    plie_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- sv/plie_dpath.sv -----
`include "positional_list_insert_erase_unit_defines.svh"

module plie_dpath
    import plie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  request_t   request,
    input  ctrl_cmd_t  ctl,
    output dp_stat_t   stat,
    output logic       done,
    output result_t    result
);

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    command_t                 cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;
    logic [LEN_W-1:0]         count_reg;
    logic [LEN_W-1:0]         count_next;
    logic [ADDR_W-1:0]        ptr_reg;
    logic [ADDR_W-1:0]        ptr_next;
    logic [ADDR_W-1:0]        dst_reg;
    logic [ADDR_W-1:0]        dst_next;
    logic                     pend_reg;
    logic [ELEMENT_WIDTH-1:0] rdata_reg;
    logic                     done_reg;
    result_t                  result_reg;
    result_t                  result_next;
    status_t                  chk_status;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [LEN_W-1:0]         count_m1;

    assign count_m1 = count_reg - LEN_W'(1);

    // Check the latched word against the current length
    always_comb
    begin
        chk_status = ST_OK;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (count_reg >= LEN_W'(CAPACITY))
                    chk_status = ST_FULL;
                else if (pos_reg > count_reg)
                    chk_status = ST_RANGE;
            end
            CMD_ERASE, CMD_READ:
            begin
                if (count_reg == '0)
                    chk_status = ST_EMPTY;
                else if (pos_reg >= count_reg)
                    chk_status = ST_RANGE;
            end
            default: chk_status = ST_OK;
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        stat.is_ok   = (chk_status == ST_OK);
        stat.command = cmd_reg;
        if (cmd_reg == CMD_INSERT)
        begin
            stat.has_moves = (pos_reg < count_reg);
            stat.last_src  = (LEN_W'(ptr_reg) == pos_reg);
        end
        else
        begin
            stat.has_moves = ({1'b0, pos_reg} + 8'd1) < {1'b0, count_reg};
            stat.last_src  = (LEN_W'(ptr_reg) == count_m1);
        end
    end

    // Latch the command word
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= request.command;
            pos_reg <= request.position;
            val_reg <= request.item_value[ELEMENT_WIDTH-1:0];
        end
    end

    // Walk the source pointer; insert moves down, erase moves up
    always_comb
    begin
        ptr_next = ptr_reg;
        dst_next = dst_reg;
        if (ctl.init_ptr)
        begin
            if (cmd_reg == CMD_INSERT)
                ptr_next = ADDR_W'(count_m1);
            else
                ptr_next = ADDR_W'(pos_reg + POS_W'(1));
        end
        else if (ctl.shift_step)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                ptr_next = ptr_reg - ADDR_W'(1);
                dst_next = ptr_reg + ADDR_W'(1);
            end
            else
            begin
                ptr_next = ptr_reg + ADDR_W'(1);
                dst_next = ptr_reg - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        dst_reg <= dst_next;
    end

    // Memory read port
    assign rd_en   = ctl.shift_step | ctl.read_issue;
    assign rd_addr = ctl.read_issue ? ADDR_W'(pos_reg) : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Memory write port: moved word in the cycle after its read, or the new word
    always_ff @(posedge clk)
    begin
        if (pend_reg)
            mem[dst_reg] <= rdata_reg;
        else if (ctl.put_word)
            mem[ADDR_W'(pos_reg)] <= val_reg;
    end

    // Length after the command
    always_comb
    begin
        count_next = count_reg;
        if (ctl.finish)
        begin
            if (cmd_reg == CMD_CLEAR)
                count_next = '0;
            else if (chk_status == ST_OK && cmd_reg == CMD_INSERT)
                count_next = count_reg + LEN_W'(1);
            else if (chk_status == ST_OK && cmd_reg == CMD_ERASE)
                count_next = count_m1;
        end
    end

    // Build the result word
    always_comb
    begin
        result_next.status      = chk_status;
        result_next.list_length = count_next;
        if (cmd_reg == CMD_READ && chk_status == ST_OK)
            result_next.read_value = VALUE_W'(rdata_reg);
        else
            result_next.read_value = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= ctl.shift_step;
            done_reg  <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PLIE_ASSERT_NOW(a_no_port_clash, ctl.put_word, !pend_reg, "write port clash")
    `PLIE_ASSERT_NOW(a_len_bound, 1'b1, count_reg <= LEN_W'(CAPACITY), "length over capacity")
    `PLIE_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe longer than one cycle")
    `PLIE_ASSERT_NOW(a_fail_zero, done_reg && result_reg.status != ST_OK,
        result_reg.read_value == '0, "failed command returned data")

endmodule

// ----- sv/plie_ctrl.sv -----
module plie_ctrl
    import plie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  ctl,
    output logic       busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_READ   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one command
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.init_ptr = 1'b1;
                if (!stat.is_ok || stat.command == CMD_CLEAR)
                    state_next = S_FINISH;
                else if (stat.command == CMD_READ)
                    state_next = S_READ;
                else if (stat.has_moves)
                    state_next = S_SHIFT;
                else if (stat.command == CMD_INSERT)
                    state_next = S_PUT;
                else
                    state_next = S_FINISH;
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (stat.last_src)
                    state_next = (stat.command == CMD_INSERT) ? S_DRAIN : S_FINISH;
            end
            S_DRAIN:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                ctl.put_word = 1'b1;
                ctl.finish   = 1'b1;
                state_next   = S_IDLE;
            end
            S_READ:
            begin
                ctl.read_issue = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- tb/list_result_checker.sv -----
`timescale 1ns / 100ps

// Watch the command and result channels of the list unit, keep a shadow copy
// of the list, and compare every result word with the oldest prediction.
module list_result_checker
    import plie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       mismatches,
    output int       waiting
);

    logic [ELEMENT_WIDTH-1:0] shadow_words [CAPACITY];
    int                       shadow_length;
    result_t                  expected_results [$];
    int                       error_total;

    // Apply one command to the shadow list and return the result word it gives
    function automatic result_t apply_list_command(request_t cmd_word);
        result_t outcome;
        int      pos;
        begin
            pos                 = int'(cmd_word.position);
            outcome.status      = ST_OK;
            outcome.read_value  = '0;
            case (cmd_word.command)
                CMD_INSERT:
                begin
                    if (shadow_length >= CAPACITY)
                        outcome.status = ST_FULL;
                    else if (pos > shadow_length)
                        outcome.status = ST_RANGE;
                    else
                    begin
                        for (int i = shadow_length; i > pos; i--)
                            shadow_words[i] = shadow_words[i-1];
                        shadow_words[pos] = cmd_word.item_value[ELEMENT_WIDTH-1:0];
                        shadow_length++;
                    end
                end
                CMD_ERASE:
                begin
                    if (shadow_length == 0)
                        outcome.status = ST_EMPTY;
                    else if (pos >= shadow_length)
                        outcome.status = ST_RANGE;
                    else
                    begin
                        for (int i = pos; i + 1 < shadow_length; i++)
                            shadow_words[i] = shadow_words[i+1];
                        shadow_words[shadow_length-1] = '0;
                        shadow_length--;
                    end
                end
                CMD_READ:
                begin
                    if (shadow_length == 0)
                        outcome.status = ST_EMPTY;
                    else if (pos >= shadow_length)
                        outcome.status = ST_RANGE;
                    else
                        outcome.read_value = VALUE_W'(shadow_words[pos]);
                end
                default:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        shadow_words[i] = '0;
                    shadow_length = 0;
                end
            endcase
            outcome.list_length = LEN_W'(shadow_length);
            return outcome;
        end
    endfunction

    // Check results first, then predict: a word may be taken at the edge
    // that also takes the previous result
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            shadow_length = 0;
            error_total   = 0;
            expected_results.delete();
            mismatches <= 0;
            waiting    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no command pending");
                    error_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        error_total++;
                    end
                    if (result.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %08h, got %08h",
                               want.read_value, result.read_value);
                        error_total++;
                    end
                    if (result.list_length !== want.list_length)
                    begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, result.list_length);
                        error_total++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_list_command(request));
            mismatches <= error_total;
            waiting    <= expected_results.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import plie_pkg::*;

    localparam int RANDOM_WORDS = 1030;
    localparam int CALM_TAIL    = 150;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    int       mismatches;
    int       waiting;

    // Length as seen by the stimulus, used to aim positions and for the peak and full counts
    int       stim_length;
    int       peak_length;
    int       full_hits;
    int       sent_by_command [4];
    int       idle_percent;

    positional_list_insert_erase_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    list_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Present one command word and hold it until the unit takes it
    task automatic send_word(command_t cmd, int pos, logic [VALUE_W-1:0] value);
        request_t w;
        begin
            w.command    = cmd;
            w.position   = POS_W'(pos);
            w.item_value = value;
            start   <= 1'b1;
            request <= w;
            do
                @(posedge clk);
            while (busy);
            sent_by_command[int'(cmd)]++;
            case (cmd)
                CMD_INSERT:
                begin
                    if (stim_length >= CAPACITY)
                        full_hits++;
                    else if (pos <= stim_length)
                        stim_length++;
                end
                CMD_ERASE:
                    if (stim_length > 0 && pos < stim_length)
                        stim_length--;
                CMD_READ:
                    ;
                default:
                    stim_length = 0;
            endcase
            if (stim_length > peak_length)
                peak_length = stim_length;
        end
    endtask

    // Drop start for a random burst, or not at all
    task automatic maybe_idle(int chance);
        begin
            if ($urandom_range(0, 99) < chance)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    endtask

    // Pick a position: mostly legal for the current length, ends favored,
    // some anywhere in the 7-bit field
    function automatic int aim_position(command_t cmd);
        int top_ok;
        int roll;
        begin
            top_ok = (cmd == CMD_INSERT) ? stim_length : stim_length - 1;
            roll   = $urandom_range(0, 99);
            if (roll < 15 || top_ok < 0)
                return $urandom_range(0, (1 << POS_W) - 1);
            else if (roll < 25)
                return 0;
            else if (roll < 35)
                return top_ok;
            else
                return $urandom_range(0, top_ok);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                return '0;
            else if (roll < 8)
                return '1;
            else
                return $urandom();
        end
    endfunction

    // Choose a command by phase: grow, mixed, shrink
    function automatic command_t pick_command(int phase);
        int roll;
        begin
            if ($urandom_range(0, 999) < 5)
                return CMD_CLEAR;
            roll = $urandom_range(0, 99);
            case (phase)
                0:       return (roll < 72) ? CMD_INSERT : (roll < 84) ? CMD_READ : CMD_ERASE;
                1:       return (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_READ : CMD_ERASE;
                default: return (roll < 70) ? CMD_ERASE : (roll < 85) ? CMD_READ : CMD_INSERT;
            endcase
        end
    endfunction

    initial
    begin
        command_t cmd;
        int       guard;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        stim_length  = 0;
        peak_length  = 0;
        full_hits    = 0;
        idle_percent = 30;
        for (int i = 0; i < 4; i++)
            sent_by_command[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, range edges, ends and middle, clear
        send_word(CMD_READ,   0,   32'h0);
        send_word(CMD_ERASE,  0,   32'h0);
        send_word(CMD_READ,   127, 32'h0);
        send_word(CMD_INSERT, 1,   32'h1234_5678);
        send_word(CMD_INSERT, 0,   32'hFFFF_FFFF);
        send_word(CMD_INSERT, 1,   32'h0000_0000);
        maybe_idle(100);
        send_word(CMD_INSERT, 0,   32'hA5A5_A5A5);
        send_word(CMD_INSERT, 4,   32'hDEAD_BEEF);
        send_word(CMD_INSERT, 127, 32'hDEAD_BEEF);
        send_word(CMD_INSERT, 2,   32'h5A5A_5A5A);
        for (int p = 0; p <= 4; p++)
            send_word(CMD_READ, p, 32'hFFFF_FFFF);
        send_word(CMD_ERASE,  4,   32'h0);
        send_word(CMD_ERASE,  127, 32'h0);
        send_word(CMD_ERASE,  1,   32'h0);
        maybe_idle(100);
        send_word(CMD_ERASE,  2,   32'h0);
        send_word(CMD_ERASE,  0,   32'h0);
        send_word(CMD_READ,   0,   32'h0);
        send_word(CMD_CLEAR,  0,   32'hFFFF_FFFF);
        send_word(CMD_READ,   0,   32'h0);
        send_word(CMD_ERASE,  0,   32'h0);

        // Random: phases long enough to fill the list and sit at full
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                idle_percent = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            if (n < RANDOM_WORDS - CALM_TAIL)
                maybe_idle(idle_percent);
            cmd = pick_command((n / 200) % 3);
            send_word(cmd, aim_position(cmd), pick_value());
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for the longest command
        guard = 0;
        while (waiting != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);

        $display("Sent %0d inserts, %0d erases, %0d reads, %0d clears",
                 sent_by_command[int'(CMD_INSERT)], sent_by_command[int'(CMD_ERASE)],
                 sent_by_command[int'(CMD_READ)], sent_by_command[int'(CMD_CLEAR)]);
        $display("Longest list %0d of %0d, %0d inserts refused as full, %0d mismatches",
                 peak_length, CAPACITY, full_hits, mismatches);
        if (mismatches == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
